>>> design/pidc_pkg.sv
`default_nettype none

package pidc_pkg;

    localparam int DATA_W      = 16;
    localparam int SAMPLE_W    = 16;
    localparam int ERR_W       = ((SAMPLE_W > DATA_W) ? SAMPLE_W : DATA_W) + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd6;

    localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = 16'sh8000;
    localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = 16'sh7FFF;

    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] measurement;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     done_res;
    } result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic        [DATA_W-1:0] tolerance;
        logic signed [DATA_W-1:0] out_min;
        logic signed [DATA_W-1:0] out_max;
        logic signed [DATA_W-1:0] target;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_DONE,
        KIND_RUN
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [SAMPLE_W-1:0] measurement;
        logic signed [ERR_W-1:0]    err;
    } entry_t;

endpackage

`default_nettype wire

>>> design/pidc_front.sv
`default_nettype none

module pidc_front
    import pidc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    sample_valid,
    output logic         sample_stall,
    input  wire sample_t sample,
    input  wire logic    q_full,
    output logic         q_push,
    output entry_t       q_data
);

    logic                    armed_reg;
    logic                    armed_next;
    logic                    accept;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W:0]   err_ext;
    logic signed [ERR_W:0]   tol_ext;
    logic                    in_tol;

    assign sample_stall = q_full;
    assign accept       = sample_valid && !q_full;

    always_comb
    begin
        err     = ERR_W'($signed(cfg.target)) - ERR_W'($signed(sample.measurement));
        err_ext = (ERR_W + 1)'(err);
        tol_ext = $signed({1'b0, ERR_W'(cfg.tolerance)});
        in_tol  = (err_ext < tol_ext) && (err_ext > -tol_ext);

        armed_next         = armed_reg;
        q_push             = 1'b0;
        q_data.measurement = sample.measurement;
        q_data.err         = err;
        q_data.kind        = KIND_RUN;
        if (accept)
        begin
            if (sample.command)
            begin
                q_push      = 1'b1;
                q_data.kind = KIND_START;
                armed_next  = 1'b1;
            end
            else if (armed_reg)
            begin
                q_push = 1'b1;
                if (in_tol)
                begin
                    q_data.kind = KIND_DONE;
                    armed_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
        end
    end

endmodule

`default_nettype wire

>>> design/pidc_queue.sv
`default_nettype none

module pidc_queue
    import pidc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        valid,
    output entry_t      pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> design/pidc_back.sv
`default_nettype none

module pidc_back
    import pidc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   q_valid,
    input  wire entry_t q_data,
    output logic        q_pop,
    output logic        result_valid,
    input  wire logic   result_stall,
    output result_t     result
);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DATA_W + ERR_W;
    localparam int PD_W   = DATA_W + DIFF_W;
    localparam int INT_W  = DATA_W + GAIN_FRAC_BITS;
    localparam int ACC_W  = ((PROD_W > INT_W) ? PROD_W : INT_W) + 1;
    localparam int WIDE_W = (PROD_W > INT_W) ? PROD_W : INT_W;
    localparam int SUM_W  = ((WIDE_W > PD_W) ? WIDE_W : PD_W) + 2;

    logic                       en;

    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [INT_W-1:0]    integ_reg;
    logic signed [INT_W-1:0]    integ_next;

    logic                       a_valid_reg;
    kind_t                      a_kind_reg;
    logic signed [ERR_W-1:0]    a_err_reg;
    logic signed [DIFF_W-1:0]   a_diff_reg;
    logic signed [DIFF_W-1:0]   a_diff_next;

    logic                       b_valid_reg;
    kind_t                      b_kind_reg;
    logic signed [PROD_W-1:0]   b_pp_reg;
    logic signed [PROD_W-1:0]   b_pi_reg;
    logic signed [PD_W-1:0]     b_pd_reg;

    logic                       c_valid_reg;
    kind_t                      c_kind_reg;
    logic signed [PROD_W-1:0]   c_pp_reg;
    logic signed [PD_W-1:0]     c_pd_reg;
    logic signed [INT_W-1:0]    c_integ_reg;

    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_hi;
    logic signed [ACC_W-1:0]    acc_lo;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sum_floor;
    logic signed [SUM_W-1:0]    sum_hi;
    logic signed [SUM_W-1:0]    sum_lo;
    logic signed [SUM_W-1:0]    sum_clamped;

    logic                       result_valid_reg;
    logic                       result_valid_next;
    result_t                    result_reg;
    result_t                    result_next;

    assign en           = !result_valid_reg || !result_stall;
    assign q_pop        = en && q_valid;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign a_diff_next = DIFF_W'($signed(q_data.measurement)) - DIFF_W'(prev_reg);

    always_comb
    begin
        acc    = ACC_W'(integ_reg) + ACC_W'(b_pi_reg);
        acc_hi = ACC_W'($signed(cfg.out_max)) <<< GAIN_FRAC_BITS;
        acc_lo = ACC_W'($signed(cfg.out_min)) <<< GAIN_FRAC_BITS;
        if (acc > acc_hi)
        begin
            integ_next = INT_W'(acc_hi);
        end
        else if (acc < acc_lo)
        begin
            integ_next = INT_W'(acc_lo);
        end
        else
        begin
            integ_next = INT_W'(acc);
        end
    end

    always_comb
    begin
        sum       = SUM_W'(c_pp_reg) + SUM_W'(c_integ_reg) - SUM_W'(c_pd_reg);
        sum_floor = sum >>> GAIN_FRAC_BITS;
        sum_hi    = SUM_W'($signed(cfg.out_max));
        sum_lo    = SUM_W'($signed(cfg.out_min));
        if (sum_floor > sum_hi)
        begin
            sum_clamped = sum_hi;
        end
        else if (sum_floor < sum_lo)
        begin
            sum_clamped = sum_lo;
        end
        else
        begin
            sum_clamped = sum_floor;
        end

        result_next       = result_reg;
        result_valid_next = 1'b0;
        case (c_kind_reg)
            KIND_DONE:
            begin
                result_valid_next    = c_valid_reg;
                result_next.drive    = '0;
                result_next.done_res = 1'b1;
            end
            KIND_RUN:
            begin
                result_valid_next    = c_valid_reg;
                result_next.drive    = sum_clamped[DATA_W-1:0];
                result_next.done_res = 1'b0;
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_kind_reg  <= q_data.kind;
            a_err_reg   <= q_data.err;
            a_diff_reg  <= a_diff_next;

            b_kind_reg  <= a_kind_reg;
            b_pp_reg    <= PROD_W'($signed(cfg.gain_p)) * PROD_W'(a_err_reg);
            b_pi_reg    <= PROD_W'($signed(cfg.gain_i)) * PROD_W'(a_err_reg);
            b_pd_reg    <= PD_W'($signed(cfg.gain_d)) * PD_W'(a_diff_reg);

            c_kind_reg  <= b_kind_reg;
            c_pp_reg    <= b_pp_reg;
            c_pd_reg    <= b_pd_reg;
            c_integ_reg <= integ_next;

            result_reg  <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg         <= '0;
            integ_reg        <= '0;
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg      <= q_valid;
            b_valid_reg      <= a_valid_reg;
            c_valid_reg      <= b_valid_reg;
            result_valid_reg <= result_valid_next;
            if (q_valid && (q_data.kind != KIND_DONE))
            begin
                prev_reg <= q_data.measurement;
            end
            if (b_valid_reg && (b_kind_reg == KIND_START))
            begin
                integ_reg <= '0;
            end
            else if (b_valid_reg && (b_kind_reg == KIND_RUN))
            begin
                integ_reg <= integ_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/pid_controller_clamped.sv
// PID regulator with derivative on measurement and clamped integral and drive. A start beat
// latches its measurement as the previous one, clears the integral, arms the loop and gives
// no result; an armed sample beat gives one result, either done (drive zero, loop disarmed)
// when the error magnitude is below tolerance, or the clamped drive. One beat is accepted per
// clock while the queue is not full; the front end classifies it against the armed flag and a
// two-entry queue feeds a four-register back end (difference, three parallel multipliers,
// integral update, final sum and clamp); the sustained rate is one item per cycle while the
// result is not stalled, with the integral accumulator closing its loop in a single stage.
// The user must write configuration registers only while the block is idle; it is not enforced.
`default_nettype none

module pid_controller_clamped
    import pidc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire sample_t              sample,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result
);

    cfg_t   cfg_reg;
    logic   q_full;
    logic   q_push;
    entry_t q_push_data;
    logic   q_pop;
    logic   q_valid;
    entry_t q_pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p    <= '0;
            cfg_reg.gain_i    <= '0;
            cfg_reg.gain_d    <= '0;
            cfg_reg.tolerance <= '0;
            cfg_reg.out_min   <= OUT_MIN_RESET;
            cfg_reg.out_max   <= OUT_MAX_RESET;
            cfg_reg.target    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P:    cfg_reg.gain_p    <= cfg_data;
                REG_GAIN_I:    cfg_reg.gain_i    <= cfg_data;
                REG_GAIN_D:    cfg_reg.gain_d    <= cfg_data;
                REG_TOLERANCE: cfg_reg.tolerance <= cfg_data;
                REG_OUT_MIN:   cfg_reg.out_min   <= cfg_data;
                REG_OUT_MAX:   cfg_reg.out_max   <= cfg_data;
                REG_TARGET:    cfg_reg.target    <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    pidc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    pidc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    pidc_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> design/pidc_checker.sv
`default_nettype none

module pidc_checker
    import pidc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cfg_we,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [DATA_W-1:0]    cfg_data,
    input wire logic                 result_valid,
    input wire logic                 result_stall,
    input wire result_t              result
);

    logic signed [DATA_W-1:0] out_min_reg;
    logic signed [DATA_W-1:0] out_max_reg;
    logic                     limits_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_min_reg <= OUT_MIN_RESET;
            out_max_reg <= OUT_MAX_RESET;
        end
        else if (cfg_we && (cfg_index == REG_OUT_MIN))
        begin
            out_min_reg <= cfg_data;
        end
        else if (cfg_we && (cfg_index == REG_OUT_MAX))
        begin
            out_max_reg <= cfg_data;
        end
    end

    assign limits_ok = (out_min_reg <= out_max_reg);

    assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("Result beat offered during reset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("Stalled result beat changed or was withdrawn.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.done_res |-> result.drive == '0)
        else $error("Done result carries a nonzero drive.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.done_res && limits_ok
        |-> (result.drive <= out_max_reg) && (result.drive >= out_min_reg))
        else $error("Drive lies outside the output limits.");

endmodule

bind pid_controller_clamped pidc_checker u_checker (.*);

`default_nettype wire
